### hw/rtl/chs_pkg.sv
// Shared types, constants and helpers for the cosine hemisphere sampler.
// No dependencies; used by every module in hw/rtl.
package chs_pkg;

  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned ROT_STAGES = 16;
  localparam logic [29:0] GAIN_Q30 = 30'h26DD3B6A;
  localparam logic [31:0] INV_PI_Q32 = 32'h517CC1B7;
  localparam logic [15:0] PDF_FLOOR_RESET = 16'd1;

  localparam logic [31:0] ATAN_TURNS [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  // one word in flight through a square-root cell
  typedef struct packed {
    logic        valid;
    logic [61:0] rad;
    logic [34:0] rem;
    logic [30:0] root;
    logic [31:0] side;
  } sq_t;

  // one word in flight through a rotation cell
  typedef struct packed {
    logic               valid;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    logic [1:0]         quad;
  } cr_t;

  // Q0.30 signed to Q1.15, magnitude rounded half away from zero, saturated
  function automatic logic [15:0] to_q15(input logic signed [33:0] v);
    logic [33:0] mag;
    logic [33:0] rnd;
    logic [15:0] res;
    mag = v[33] ? 34'(-v) : 34'(v);
    rnd = (mag + 34'd16384) >> 15;
    if (v[33]) begin
      res = (rnd >= 34'd32768) ? 16'h8000 : 16'(-rnd);
    end else begin
      res = (rnd > 34'd32767) ? 16'h7FFF : rnd[15:0];
    end
    return res;
  endfunction

endpackage

### hw/rtl/chs_sqrt_cell.sv
// One digit cell of the pipelined integer square root: two radicand bits per cell.
// Depends on chs_pkg.
module chs_sqrt_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  chs_pkg::sq_t  din,
  output chs_pkg::sq_t  dout
);

  logic [34:0] rem_sh;
  logic [34:0] trial;
  chs_pkg::sq_t nxt;

  always_comb begin
    rem_sh = {din.rem[32:0], din.rad[61:60]};
    trial  = {2'b00, din.root, 2'b01};
    nxt       = din;
    nxt.rad   = {din.rad[59:0], 2'b00};
    if (rem_sh >= trial) begin
      nxt.rem  = rem_sh - trial;
      nxt.root = {din.root[29:0], 1'b1};
    end else begin
      nxt.rem  = rem_sh;
      nxt.root = {din.root[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.rad  <= nxt.rad;
      dout.rem  <= nxt.rem;
      dout.root <= nxt.root;
      dout.side <= nxt.side;
    end
  end

endmodule

### hw/rtl/chs_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation; step selects shift and arctangent.
// Depends on chs_pkg.
module chs_cordic_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic [4:0]    step,
  input  chs_pkg::cr_t  din,
  output chs_pkg::cr_t  dout
);

  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] ang;
  chs_pkg::cr_t nxt;

  always_comb begin
    xs  = din.x >>> step;
    ys  = din.y >>> step;
    ang = $signed({2'b00, chs_pkg::ATAN_TURNS[step]});
    nxt = din;
    if (!din.z[33]) begin
      nxt.x = din.x - ys;
      nxt.y = din.y + xs;
      nxt.z = din.z - ang;
    end else begin
      nxt.x = din.x + ys;
      nxt.y = din.y - xs;
      nxt.z = din.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout.valid <= din.valid;
    end
    if (en) begin
      dout.x    <= nxt.x;
      dout.y    <= nxt.y;
      dout.z    <= nxt.z;
      dout.quad <= nxt.quad;
    end
  end

endmodule

### hw/rtl/cosine_hemisphere_sampler.sv
// Top level of the cosine-weighted hemisphere sampler.
// Depends on chs_pkg, chs_sqrt_cell and chs_cordic_cell.

// Fully pipelined: a new (u1, u2) word is taken every cycle unless the output stalls.
// The pipe is made of two 31-cell square-root chains (radius and z) and a 16-cell
// CORDIC chain, plus the gain, quadrant, squaring and pdf stages. The whole pipeline
// holds while the output word is waiting, so s_tready falls only then.
// pdf_floor is sampled late in the pipe; write it while no words are in flight.
module cosine_hemisphere_sampler (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // u1 [15:0], u2 [31:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // dir_x [15:0], dir_y [31:16], dir_z [46:32], pdf [62:47]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic         en;
  logic [15:0]  pdf_floor;
  chs_pkg::sq_t sq1 [chs_pkg::SQRT_STEPS+1];
  chs_pkg::sq_t sq2 [chs_pkg::SQRT_STEPS+1];
  chs_pkg::cr_t cr  [chs_pkg::ROT_STAGES+1];

  logic               q_valid;
  logic signed [33:0] q_c;
  logic signed [33:0] q_s;
  logic               m_valid;
  logic [63:0]        c2;
  logic [63:0]        s2;
  logic [31:0]        m_dxy;
  logic [64:0]        sum;
  logic [60:0]        diff;
  logic [60:0]        rgain;
  logic [33:0]        c_mag;
  logic [33:0]        s_mag;

  logic               p1_valid;
  logic [30:0]        p1_m;
  logic [14:0]        p1_dz;
  logic [31:0]        p1_dxy;
  logic [30:0]        floor_q30;
  logic [16:0]        dz_rnd;
  logic               p2_valid;
  logic [62:0]        p2_prod;
  logic [14:0]        p2_dz;
  logic [31:0]        p2_dxy;
  logic [62:0]        pdf_rnd;
  logic [15:0]        pdf_sat;

  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pdf_floor <= chs_pkg::PDF_FLOOR_RESET;
    end else if (cfg_valid) begin
      pdf_floor <= cfg_data;
    end
  end

  // radius = isqrt(u1 << 44)
  always_comb begin
    sq1[0].valid = s_tvalid && en;
    sq1[0].rad   = {2'b00, s_tdata[15:0], 44'd0};
    sq1[0].rem   = '0;
    sq1[0].root  = '0;
    sq1[0].side  = {16'd0, s_tdata[31:16]};
  end

  for (genvar i = 0; i < chs_pkg::SQRT_STEPS; i++) begin : g_sq1
    chs_sqrt_cell u_cell (.clk(clk), .rst(rst), .en(en), .din(sq1[i]), .dout(sq1[i+1]));
  end

  // scale by the CORDIC gain, split the angle into quadrant and remainder
  assign rgain = 61'(sq1[chs_pkg::SQRT_STEPS].root) * 61'(chs_pkg::GAIN_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      cr[0].valid <= 1'b0;
    end else if (en) begin
      cr[0].valid <= sq1[chs_pkg::SQRT_STEPS].valid;
    end
    if (en) begin
      cr[0].x    <= $signed({3'b000, rgain[60:30]});
      cr[0].y    <= '0;
      cr[0].z    <= $signed({4'b0000, sq1[chs_pkg::SQRT_STEPS].side[13:0], 16'd0});
      cr[0].quad <= sq1[chs_pkg::SQRT_STEPS].side[15:14];
    end
  end

  for (genvar j = 0; j < chs_pkg::ROT_STAGES; j++) begin : g_rot
    chs_cordic_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .step(5'(j)), .din(cr[j]), .dout(cr[j+1])
    );
  end

  // quadrant unfold
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (en) begin
      q_valid <= cr[chs_pkg::ROT_STAGES].valid;
    end
    if (en) begin
      case (cr[chs_pkg::ROT_STAGES].quad)
        2'd0: begin
          q_c <= cr[chs_pkg::ROT_STAGES].x;
          q_s <= cr[chs_pkg::ROT_STAGES].y;
        end
        2'd1: begin
          q_c <= -cr[chs_pkg::ROT_STAGES].y;
          q_s <= cr[chs_pkg::ROT_STAGES].x;
        end
        2'd2: begin
          q_c <= -cr[chs_pkg::ROT_STAGES].x;
          q_s <= -cr[chs_pkg::ROT_STAGES].y;
        end
        default: begin
          q_c <= cr[chs_pkg::ROT_STAGES].y;
          q_s <= -cr[chs_pkg::ROT_STAGES].x;
        end
      endcase
    end
  end

  // square the components, round x and y for output
  assign c_mag = q_c[33] ? 34'(-q_c) : 34'(q_c);
  assign s_mag = q_s[33] ? 34'(-q_s) : 34'(q_s);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (en) begin
      m_valid <= q_valid;
    end
    if (en) begin
      c2    <= c_mag[31:0] * c_mag[31:0];
      s2    <= s_mag[31:0] * s_mag[31:0];
      m_dxy <= {chs_pkg::to_q15(q_s), chs_pkg::to_q15(q_c)};
    end
  end

  // z = isqrt(max(0, 1 - c^2 - s^2))
  assign sum  = {1'b0, c2} + {1'b0, s2};
  assign diff = (sum > 65'(61'h1000000000000000)) ? '0
              : 61'(65'(61'h1000000000000000) - sum);

  always_comb begin
    sq2[0].valid = m_valid;
    sq2[0].rad   = {1'b0, diff};
    sq2[0].rem   = '0;
    sq2[0].root  = '0;
    sq2[0].side  = m_dxy;
  end

  for (genvar k = 0; k < chs_pkg::SQRT_STEPS; k++) begin : g_sq2
    chs_sqrt_cell u_cell (.clk(clk), .rst(rst), .en(en), .din(sq2[k]), .dout(sq2[k+1]));
  end

  // pdf: max(floor, z) / pi
  assign floor_q30 = {1'b0, pdf_floor, 14'd0};
  assign dz_rnd    = 17'((32'(sq2[chs_pkg::SQRT_STEPS].root) + 32'd16384) >> 15);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else if (en) begin
      p1_valid <= sq2[chs_pkg::SQRT_STEPS].valid;
      p2_valid <= p1_valid;
    end
    if (en) begin
      p1_m    <= (sq2[chs_pkg::SQRT_STEPS].root > floor_q30)
                 ? sq2[chs_pkg::SQRT_STEPS].root : floor_q30;
      p1_dz   <= (dz_rnd > 17'd32767) ? 15'h7FFF : dz_rnd[14:0];
      p1_dxy  <= sq2[chs_pkg::SQRT_STEPS].side;
      p2_prod <= 63'(p1_m) * 63'(chs_pkg::INV_PI_Q32);
      p2_dz   <= p1_dz;
      p2_dxy  <= p1_dxy;
    end
  end

  assign pdf_rnd = (p2_prod + 63'(64'h0000200000000000)) >> 46;
  assign pdf_sat = (pdf_rnd > 63'd65535) ? 16'hFFFF : pdf_rnd[15:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= p2_valid;
    end
    if (en) begin
      m_tdata <= {1'b0, pdf_sat, p2_dz, p2_dxy};
    end
  end

  a_gain_follows_sqrt: assert property (@(posedge clk) disable iff (rst)
    en && sq1[chs_pkg::SQRT_STEPS].valid |=> cr[0].valid)
    else $error("radius word lost before rotation");

  a_quad_follows_rot: assert property (@(posedge clk) disable iff (rst)
    en && cr[chs_pkg::ROT_STAGES].valid |=> q_valid)
    else $error("rotated word lost before quadrant unfold");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(p2_prod) && $stable(p2_valid))
    else $error("pipeline moved while output stalled");

endmodule

### sim/cosine_hemisphere_sampler_tb.sv
// Self-checking testbench for cosine_hemisphere_sampler: streams (u1, u2) words,
// predicts direction and pdf in a scoreboard class. Depends on chs_pkg and the RTL.
`timescale 1ns / 100ps

module cosine_hemisphere_sampler_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 100;

  class sample_scoreboard;
    logic [63:0] expected_q[$];
    logic [15:0] pdf_floor;
    int errors;

    function new();
      pdf_floor = chs_pkg::PDF_FLOOR_RESET;
      errors = 0;
    endfunction

    function longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    // Q0.30 to Q1.15, magnitude rounded half away from zero, clamped to [lo, hi]
    function logic [15:0] round_q15(input longint v, input longint lo, input longint hi);
      longint unsigned mag;
      longint r;
      mag = (v < 0) ? longint'(-v) : v;
      mag = (mag + 64'd16384) >> 15;
      if (mag > (64'd1 << 40)) mag = 64'd1 << 40;
      r = (v < 0) ? -longint'(mag) : longint'(mag);
      if (r < lo) r = lo;
      if (r > hi) r = hi;
      return r[15:0];
    endfunction

    function logic [63:0] predict_sample(input logic [15:0] u1, input logic [15:0] u2);
      longint unsigned radius, sum, zq, m, pdf;
      longint x, y, z, c, s, d, xs, ys;
      logic [31:0] turns;
      logic [63:0] word;
      logic [15:0] z_code;
      radius = int_sqrt(longint'(u1) << 44);
      turns = {u2, 16'h0};
      z = longint'(turns[29:0]);
      x = (radius * chs_pkg::GAIN_Q30) >> 30;
      y = 0;
      for (int i = 0; i < chs_pkg::ROT_STAGES; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (z >= 0) begin
          x -= ys; y += xs; z -= longint'(chs_pkg::ATAN_TURNS[i]);
        end else begin
          x += ys; y -= xs; z += longint'(chs_pkg::ATAN_TURNS[i]);
        end
      end
      case (turns[31:30])
        2'd0: begin c = x;  s = y;  end
        2'd1: begin c = -y; s = x;  end
        2'd2: begin c = -x; s = -y; end
        default: begin c = y; s = -x; end
      endcase
      sum = c * c + s * s;
      d = longint'(64'd1 << 60) - longint'(sum);
      if (d < 0) d = 0;
      zq = int_sqrt(d);
      m = longint'(pdf_floor) << 14;
      if (zq > m) m = zq;
      pdf = (m * chs_pkg::INV_PI_Q32 + (64'd1 << 45)) >> 46;
      if (pdf > 64'hFFFF) pdf = 64'hFFFF;
      z_code = round_q15(zq, 0, 32767);
      word = '0;
      word[15:0] = round_q15(c, -32768, 32767);
      word[31:16] = round_q15(s, -32768, 32767);
      word[46:32] = z_code[14:0];
      word[62:47] = pdf[15:0];
      return word;
    endfunction

    function void note_input(input logic [31:0] tdata);
      expected_q.push_back(predict_sample(tdata[15:0], tdata[31:16]));
    endfunction

    function void check_result(input logic [63:0] tdata);
      logic [63:0] exp_word;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result word %h", tdata);
        return;
      end
      exp_word = expected_q.pop_front();
      if (tdata[15:0] !== exp_word[15:0] || tdata[31:16] !== exp_word[31:16] ||
          tdata[46:32] !== exp_word[46:32] || tdata[62:47] !== exp_word[62:47]) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: x %h/%h y %h/%h z %h/%h pdf %h/%h (expected/actual)",
                   exp_word[15:0], tdata[15:0], exp_word[31:16], tdata[31:16],
                   exp_word[46:32], tdata[46:32], exp_word[62:47], tdata[62:47]);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [31:0] s_tdata;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;

  sample_scoreboard sb = new();
  bit hold_request = 0;
  int idle_cycles = 0;
  int rx_cycle = 0;
  int hold_left = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  cosine_hemisphere_sampler i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // monitor both streams and the watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tdata);
      if (m_tvalid && m_tready) sb.check_result(m_tdata);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // receiver: rotating stall patterns, plus one long hold on request
  always @(posedge clk) begin
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 0;
      hold_left = 400;
      m_tready <= 1'b0;
    end else begin
      case ((rx_cycle / 600) % 4)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(3) != 0);
        2: m_tready <= ($urandom_range(3) == 0);
        default: m_tready <= ((rx_cycle % 7) < 3);
      endcase
    end
  end

  int burst_left = 0;
  bit no_gaps = 0;

  task automatic send_sample(input logic [15:0] u1, input logic [15:0] u2);
    int gap;
    s_tvalid <= 1'b1;
    s_tdata <= {u2, u1};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(20);
      gap = no_gaps ? 0 : $urandom_range(5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain_pipe();
    s_tvalid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_floor(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.pdf_floor = value;
  endtask

  task automatic random_samples(input int count);
    logic [15:0] u1;
    for (int n = 0; n < count; n++) begin
      u1 = 16'($urandom);
      // lean on radii near one to reach z clamping and saturation
      if ($urandom_range(7) == 0) u1 = 16'(32'hFFFF - $urandom_range(64));
      send_sample(u1, 16'($urandom));
    end
  endtask

  logic [15:0] dir_u1 [4] = '{16'h0000, 16'h0001, 16'h8000, 16'hFFFF};
  logic [15:0] dir_u2 [6] = '{16'h0000, 16'h0001, 16'h4000, 16'h8000, 16'hC000, 16'hFFFF};
  logic [15:0] floors [5];

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // extremes of radius and every quadrant boundary, reset floor
    foreach (dir_u1[i])
      foreach (dir_u2[j])
        send_sample(dir_u1[i], dir_u2[j]);
    drain_pipe();

    floors = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0000, 16'h0001};
    floors[3] = 16'($urandom);
    for (int p = 0; p < 5; p++) begin
      write_floor(floors[p]);
      if (p == 1) begin
        // fill the pipe against a long receiver hold
        no_gaps = 1;
        hold_request = 1;
        random_samples(300);
        no_gaps = 0;
      end else begin
        random_samples(160);
      end
      drain_pipe();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
